[design/rau_pkg.sv]
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               cmp_flag;
    logic               div_zero;
  } out_t;

  // Handshake between the sequencer and the reduction unit.
  typedef struct packed {
    logic        start;
    logic [63:0] mn;
    logic [63:0] md;
  } red_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] qn;
    logic [63:0] qd;
  } red_rsp_t;

endpackage

[design/rau_reduce.sv]
module rau_reduce (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::red_req_t req,
  output rau_pkg::red_rsp_t rsp
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_GCD  = 3'b010,
    R_DIV  = 3'b100
  } rstate_t;

  rstate_t     state_r, state_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [63:0] g_r, g_nxt;
  logic [63:0] qn_r, qn_nxt, qd_r, qd_nxt;
  logic [63:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [64:0] dn, dd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    k_r   <= k_nxt;
    g_r   <= g_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    cnt_r <= cnt_nxt;
  end

  // Trial subtraction for both quotient lanes against the shared divisor.
  assign dn = {rn_r, qn_r[63]} - {1'b0, g_r};
  assign dd = {rd_r, qd_r[63]} - {1'b0, g_r};

  // Binary GCD one step a cycle, then a restoring division of both magnitudes.
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    qn_nxt    = qn_r;
    qd_nxt    = qd_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (req.start) begin
          x_nxt     = req.mn;
          y_nxt     = req.md;
          qn_nxt    = req.mn;
          qd_nxt    = req.md;
          k_nxt     = '0;
          state_nxt = R_GCD;
        end
      end
      R_GCD: begin
        if (x_r == 64'd0) begin
          g_nxt     = y_r << k_r;
          rn_nxt    = '0;
          rd_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = R_DIV;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 6'd1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r >= y_r) begin
          x_nxt = (x_r - y_r) >> 1;
        end else begin
          y_nxt = (y_r - x_r) >> 1;
        end
      end
      R_DIV: begin
        if (!dn[64]) begin
          rn_nxt = dn[63:0];
          qn_nxt = {qn_r[62:0], 1'b1};
        end else begin
          rn_nxt = {rn_r[62:0], qn_r[63]};
          qn_nxt = {qn_r[62:0], 1'b0};
        end
        if (!dd[64]) begin
          rd_nxt = dd[63:0];
          qd_nxt = {qd_r[62:0], 1'b1};
        end else begin
          rd_nxt = {rd_r[62:0], qd_r[63]};
          qd_nxt = {qd_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          done_nxt  = 1'b1;
          state_nxt = R_IDLE;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.qn   = qn_r;
  assign rsp.qd   = qd_r;

endmodule

[design/rational_arithmetic_unit.sv]
// Sequence: compare, error and zero results pass S_MUL, S_EVAL and S_DONE; reduced
// results also pass S_RED: a binary GCD loop (one step per cycle), then division.
// Throughput: one item at a time; the input stalls until the item's result is
// registered, set by the GCD loop and the two-lane restoring divider.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
module rational_arithmetic_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rau_pkg::out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_EVAL = 5'b00100,
    S_RED  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  rau_pkg::in_t      req_r, req_nxt;
  rau_pkg::out_t     res_r, res_nxt, out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic signed [63:0] l_r, l_nxt, r_r, r_nxt, dd_r, dd_nxt, nn_r, nn_nxt;
  logic              neg_r, neg_nxt;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [63:0] num, den;
  logic [63:0]       mn, md;
  rau_pkg::red_req_t red_req;
  rau_pkg::red_rsp_t red_rsp;

  rau_reduce u_reduce (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (red_req),
    .rsp  (red_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    cnt_r <= cnt_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    dd_r  <= dd_nxt;
    nn_r  <= nn_nxt;
    neg_r <= neg_nxt;
  end

  // Shared multiplier: one product per cycle.
  always_comb begin
    case (cnt_r)
      2'd0: begin
        ma = 33'(req_r.a_num);
        mb = $signed({2'b00, req_r.b_den});
      end
      2'd1: begin
        ma = 33'(req_r.b_num);
        mb = $signed({2'b00, req_r.a_den});
      end
      2'd2: begin
        ma = $signed({2'b00, req_r.a_den});
        mb = $signed({2'b00, req_r.b_den});
      end
      default: begin
        ma = 33'(req_r.a_num);
        mb = 33'(req_r.b_num);
      end
    endcase
  end
  assign prod = ma * mb;

  // Select the unreduced fraction for the operation.
  always_comb begin
    case (req_r.req_type)
      rau_pkg::OP_ADD: begin num = l_r + r_r; den = dd_r; end
      rau_pkg::OP_SUB: begin num = l_r - r_r; den = dd_r; end
      rau_pkg::OP_MUL: begin num = nn_r;      den = dd_r; end
      default:         begin num = l_r;       den = r_r;  end
    endcase
  end
  assign mn = num[63] ? 64'(-num) : 64'(num);
  assign md = den[63] ? 64'(-den) : 64'(den);

  assign red_req.start = (state_r == S_EVAL)
                         && (req_r.req_type inside {[rau_pkg::OP_ADD:rau_pkg::OP_DIV]})
                         && (req_r.a_den != '0) && (req_r.b_den != '0)
                         && !(req_r.req_type == rau_pkg::OP_DIV && req_r.b_num == '0)
                         && (mn != 64'd0);
  assign red_req.mn = mn;
  assign red_req.md = md;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    cnt_nxt       = cnt_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    dd_nxt        = dd_r;
    nn_nxt        = nn_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        case (cnt_r)
          2'd0:    l_nxt  = prod[63:0];
          2'd1:    r_nxt  = prod[63:0];
          2'd2:    dd_nxt = prod[63:0];
          default: nn_nxt = prod[63:0];
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        res_nxt          = '0;
        res_nxt.res_den  = 63'd1;
        neg_nxt          = num[63] ^ den[63];
        state_nxt        = S_DONE;
        if (req_r.req_type > rau_pkg::OP_EQ) begin
          res_nxt.div_zero = 1'b0;
        end else if (req_r.a_den == '0 || req_r.b_den == '0) begin
          res_nxt.div_zero = 1'b1;
        end else if (req_r.req_type == rau_pkg::OP_LT) begin
          res_nxt.cmp_flag = (l_r < r_r);
        end else if (req_r.req_type == rau_pkg::OP_EQ) begin
          res_nxt.cmp_flag = (l_r == r_r);
        end else if (req_r.req_type == rau_pkg::OP_DIV && req_r.b_num == '0) begin
          res_nxt.div_zero = 1'b1;
        end else if (red_req.start) begin
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (red_rsp.done) begin
          res_nxt.res_num = neg_r ? $signed(-red_rsp.qn) : $signed(red_rsp.qn);
          res_nxt.res_den = red_rsp.qd[62:0];
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/rau_checker.sv]
module rau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input rau_pkg::out_t out_data
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // After a transfer in, the unit is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while busy");

  // Error results are zero over one.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_num == 64'sd0 && out_data.res_den == 63'd1 && !out_data.cmp_flag)
    else $error("error result not zero over one");

  // A set compare flag comes with zero over one.
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmp_flag |->
      out_data.res_num == 64'sd0 && out_data.res_den == 63'd1)
    else $error("compare result not zero over one");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
